[rtl/kcd_pkg.sv]
// Package for the knob change detector: widths, reset values, codes and shared types.
// Used by the channel interfaces, the serial divider, the engine and the top level.
package kcd_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int FRAC_W     = 8;
    localparam int STEP_W     = SAMPLE_W + FRAC_W;
    localparam int AVG_W      = 16;
    localparam int TGT_W      = 16;
    localparam int TGT_SHIFT  = 20;
    localparam int SUM_W      = 26;
    localparam int CNT_W      = 10;
    localparam int CAL_W      = 16;
    localparam int LIMIT_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // shared divider: widest dividend is (sample << 20) + den/2, widest divisor is step * 100
    localparam int DIVD_W    = 33;
    localparam int DIVS_W    = 27;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

    localparam int AVG_WINDOW   = 1000;
    localparam int CAL_SAMPLES  = 1024;
    localparam int STEP_DIVISOR = 100;
    localparam int CAL_ROUND    = 50;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE  = SAMPLE_W'(4095);
    localparam logic [SAMPLE_W-1:0] MID_SAMPLE  = SAMPLE_W'(2048);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(41);
    localparam logic [AVG_W-1:0]    AVG_RESET   = AVG_W'(2048 << 4);
    localparam logic [TGT_W-1:0]    TGT_MAX     = '1;
    localparam logic [STEP_W-1:0]   UPPER_RESET =
        STEP_W'((int'(FULL_SCALE) - int'(LIMIT_RESET)) << FRAC_W);
    localparam logic [STEP_W-1:0]   LOWER_RESET = STEP_W'(int'(LIMIT_RESET) << FRAC_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INITIAL_LIMIT = 2'd0,
        REG_STORED_STEP   = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_CAL_START,
        ST_CAL_WAIT,
        ST_TGT_MUL,
        ST_TGT_START,
        ST_TGT_WAIT,
        ST_FINISH
    } kcd_state_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic              changed;
        logic [TGT_W-1:0]  target;
        logic [AVG_W-1:0]  average;
        logic [STEP_W-1:0] step;
        logic              save_request;
        logic [STEP_W-1:0] window_high;
        logic [STEP_W-1:0] window_low;
    } result_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [15:0] sat16(input logic [DIVD_W-1:0] q);
        logic [15:0] r;
        r = (q[DIVD_W-1:16] != '0) ? 16'hFFFF : q[15:0];
        return r;
    endfunction

endpackage

[rtl/kcd_if.sv]
// Valid/ready channel interfaces for sample items and result items.
// Depends on kcd_pkg for field widths.
interface kcd_req_if;
    import kcd_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output mode, output sample, input ready);
    modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface kcd_rsp_if;
    import kcd_pkg::*;

    logic              valid;
    logic              ready;
    logic              changed;
    logic [TGT_W-1:0]  target;
    logic [AVG_W-1:0]  average;
    logic [STEP_W-1:0] step;
    logic              save_request;
    logic [STEP_W-1:0] window_high;
    logic [STEP_W-1:0] window_low;

    modport source (output valid, output changed, output target, output average,
                    output step, output save_request, output window_high,
                    output window_low, input ready);
    modport sink   (input valid, input changed, input target, input average,
                    input step, input save_request, input window_high,
                    input window_low, output ready);
endinterface

[rtl/kcd_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on kcd_pkg for operand widths and request/response structs.
module kcd_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  kcd_pkg::div_req_t req,
    output kcd_pkg::div_rsp_t rsp
);
    import kcd_pkg::*;

    logic [DIVS_W-1:0]    rem_reg, rem_next;
    logic [DIVD_W-1:0]    quo_reg, quo_next;
    logic [DIVS_W-1:0]    divisor_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIVS_W:0]      shifted;
    logic [DIVS_W:0]      diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVD_W-1]};
        diff    = shifted - {1'b0, divisor_reg};
        if (shifted >= {1'b0, divisor_reg})
        begin
            rem_next = diff[DIVS_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DIVS_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/kcd_engine.sv]
// Sequencer and state of the knob change detector; drives the shared divider.
// Depends on kcd_pkg for state enum, codes, constants and structs.
module kcd_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  kcd_pkg::cfg_wr_t  cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  kcd_pkg::item_t    item,
    output logic              res_valid,
    input  logic              res_ready,
    output kcd_pkg::result_t  res,
    output kcd_pkg::div_req_t div_req,
    input  kcd_pkg::div_rsp_t div_rsp
);
    import kcd_pkg::*;

    kcd_state_t state_reg, state_next;

    logic                flag_reg;
    logic [SAMPLE_W-1:0] max_reg, min_reg;
    logic [STEP_W-1:0]   upper_reg, lower_reg, step_reg;
    logic [TGT_W-1:0]    target_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [AVG_W-1:0]    avg_reg;
    logic [CAL_W-1:0]    cal_count_reg, cal_count_next;
    logic                calibrated_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                save_reg;
    logic                cal_hit_reg;
    logic                exit_reg, exit_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [DIVS_W-1:0]   den_reg;

    logic                accept;
    logic [STEP_W-1:0]   in_pos;
    logic [AVG_W-1:0]    in_avg;
    logic [SUM_W-1:0]    sum_base;
    logic [SUM_W:0]      sum_wide;
    logic [STEP_W-1:0]   pos, max_pos, min_pos, hi_next, lo_next, lo_diff;
    logic [STEP_W:0]     hi_wide;
    logic [STEP_W-1:0]   limit_pos, limit_upper, q_step;

    assign accept = in_valid && in_ready;

    // item arrival: average sum, window check, calibration count
    always_comb
    begin
        in_pos = {item.sample, {FRAC_W{1'b0}}};
        in_avg = {item.sample, 4'b0000};
        if (sum_reg >= SUM_W'(avg_reg))
            sum_base = sum_reg - SUM_W'(avg_reg);
        else
            sum_base = '0;
        if (count_reg < CNT_W'(AVG_WINDOW))
        begin
            sum_wide   = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(in_avg);
            count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            sum_wide   = (SUM_W+1)'(sum_base) + (SUM_W+1)'(in_avg);
            count_next = count_reg;
        end
        sum_next       = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        exit_next      = (in_pos > upper_reg) || (in_pos <= lower_reg);
        cal_count_next = cal_count_reg + CAL_W'(1);
    end

    // re-centered window, clamped to the seen range
    always_comb
    begin
        pos     = {sample_reg, {FRAC_W{1'b0}}};
        max_pos = {max_reg, {FRAC_W{1'b0}}};
        min_pos = {min_reg, {FRAC_W{1'b0}}};
        hi_wide = {1'b0, pos} + {1'b0, step_reg};
        hi_next = (hi_wide > {1'b0, max_pos}) ? max_pos : hi_wide[STEP_W-1:0];
        lo_diff = pos - step_reg;
        if (pos < step_reg || lo_diff < min_pos)
            lo_next = min_pos;
        else
            lo_next = lo_diff;
        limit_pos   = {1'b0, cfg.data[LIMIT_W-1:0], {FRAC_W{1'b0}}};
        limit_upper = {FULL_SCALE - {1'b0, cfg.data[LIMIT_W-1:0]}, {FRAC_W{1'b0}}};
        q_step      = div_rsp.quotient[STEP_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (item.mode || flag_reg)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_AVG_START;
                end
            end
            ST_AVG_START: state_next = ST_AVG_WAIT;
            ST_AVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (cal_hit_reg)
                        state_next = ST_CAL_START;
                    else if (exit_reg)
                        state_next = ST_TGT_MUL;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_CAL_START: state_next = ST_CAL_WAIT;
            ST_CAL_WAIT:
            begin
                if (div_rsp.done)
                    state_next = exit_reg ? ST_TGT_MUL : ST_FINISH;
            end
            ST_TGT_MUL:   state_next = (step_reg == '0) ? ST_FINISH : ST_TGT_START;
            ST_TGT_START: state_next = ST_TGT_WAIT;
            ST_TGT_WAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs: divider operands and handshakes
    always_comb
    begin
        div_req   = '0;
        in_ready  = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_AVG_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVD_W'(sum_reg) + DIVD_W'(count_reg >> 1);
                div_req.divisor  = DIVS_W'(count_reg);
            end
            ST_CAL_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVD_W'({max_reg - min_reg, {FRAC_W{1'b0}}})
                                   + DIVD_W'(CAL_ROUND);
                div_req.divisor  = DIVS_W'(STEP_DIVISOR);
            end
            ST_TGT_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVD_W'({sample_reg, {TGT_SHIFT{1'b0}}})
                                   + DIVD_W'(den_reg >> 1);
                div_req.divisor  = den_reg;
            end
            ST_FINISH: res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            flag_reg       <= 1'b0;
            max_reg        <= MID_SAMPLE;
            min_reg        <= MID_SAMPLE;
            upper_reg      <= UPPER_RESET;
            lower_reg      <= LOWER_RESET;
            step_reg       <= LOWER_RESET;
            target_reg     <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            avg_reg        <= AVG_RESET;
            cal_count_reg  <= '0;
            calibrated_reg <= 1'b0;
            limit_reg      <= LIMIT_RESET;
            save_reg       <= 1'b0;
            cal_hit_reg    <= 1'b0;
            exit_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.we)
            begin
                if (cfg.index == REG_INITIAL_LIMIT)
                begin
                    limit_reg <= cfg.data[LIMIT_W-1:0];
                    upper_reg <= limit_upper;
                    lower_reg <= limit_pos;
                    if (!calibrated_reg)
                        step_reg <= limit_pos;
                end
                else if (cfg.index == REG_STORED_STEP)
                begin
                    if (cfg.data != '0)
                    begin
                        calibrated_reg <= 1'b1;
                        step_reg       <= cfg.data;
                    end
                    else
                    begin
                        calibrated_reg <= 1'b0;
                        step_reg       <= {1'b0, limit_reg, {FRAC_W{1'b0}}};
                    end
                end
            end
            else
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (in_valid)
                        begin
                            save_reg <= 1'b0;
                            if (item.mode)
                                flag_reg <= 1'b0;
                            else if (!flag_reg)
                            begin
                                if (max_reg < item.sample)
                                    max_reg <= item.sample;
                                else if (min_reg > item.sample)
                                    min_reg <= item.sample;
                                sum_reg   <= sum_next;
                                count_reg <= count_next;
                                exit_reg  <= exit_next;
                                if (!calibrated_reg)
                                    cal_count_reg <= cal_count_next;
                                cal_hit_reg <= !calibrated_reg
                                               && cal_count_next == CAL_W'(CAL_SAMPLES);
                            end
                        end
                    end
                    ST_AVG_WAIT:
                    begin
                        if (div_rsp.done)
                            avg_reg <= sat16(div_rsp.quotient);
                    end
                    ST_CAL_WAIT:
                    begin
                        if (div_rsp.done)
                        begin
                            step_reg <= q_step;
                            save_reg <= 1'b1;
                            if (q_step != '0)
                                calibrated_reg <= 1'b1;
                        end
                    end
                    ST_TGT_MUL:
                    begin
                        flag_reg  <= 1'b1;
                        upper_reg <= hi_next;
                        lower_reg <= lo_next;
                        if (step_reg == '0)
                            target_reg <= TGT_MAX;
                    end
                    ST_TGT_WAIT:
                    begin
                        if (div_rsp.done)
                            target_reg <= sat16(div_rsp.quotient);
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            sample_reg <= item.sample;
        if (state_reg == ST_TGT_MUL)
            den_reg <= DIVS_W'(step_reg) * DIVS_W'(STEP_DIVISOR);
    end

    assign res.changed      = flag_reg;
    assign res.target       = target_reg;
    assign res.average      = avg_reg;
    assign res.step         = step_reg;
    assign res.save_request = save_reg;
    assign res.window_high  = upper_reg;
    assign res.window_low   = lower_reg;

endmodule

[rtl/knob_change_detector_core.sv]
// Knob change detector top level: engine, shared serial divider, result register.
// A clear item or an item while the flag is set goes straight to the FINISH state; a
// sample runs the average division, then the calibration division if due and, on a
// window exit with a nonzero step, the target division. One item at a time. Reset
// (rst_n, async, low) restores detector state and the result valid flag, not its data.
module knob_change_detector_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kcd_pkg::CFG_DATA_W-1:0]  cfg_data,
    kcd_req_if.sink                         req,
    kcd_rsp_if.source                       rsp
);
    import kcd_pkg::*;

    cfg_wr_t  cfg;
    item_t    item;
    result_t  res;
    logic     res_valid;
    logic     res_ready;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // result register: the engine may take the next item while a result waits here
    logic    out_valid_reg;
    result_t out_data_reg;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign item.mode   = req.mode;
    assign item.sample = req.sample;

    // engine: all detector state, configuration writes and the step sequencer
    kcd_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    // one divider serves the average, the calibration step and the target
    kcd_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // free slot when empty or when the current result transfers this cycle
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid && res_ready)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_data_reg <= res;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.changed      = out_data_reg.changed;
    assign rsp.target       = out_data_reg.target;
    assign rsp.average      = out_data_reg.average;
    assign rsp.step         = out_data_reg.step;
    assign rsp.save_request = out_data_reg.save_request;
    assign rsp.window_high  = out_data_reg.window_high;
    assign rsp.window_low   = out_data_reg.window_low;

endmodule
